### rtl/lpvs_pkg.sv
// Package for the LRU page victim selector.
// Holds the fixed field widths and the default parameter values.
// No dependencies.
`timescale 1ns / 1ps

package lpvs_pkg;

	localparam int PROC_IDX_W = 4;
	localparam int PC_W = 12;
	localparam int BITMAP_W = 32;
	localparam int COUNT_W = 6;
	localparam int PAGE_OUT_W = 5;
	localparam int TICK_W = 32;

	// Wide enough for any page number that a program counter can produce.
	localparam int PAGE_NUM_W = 8;
	// Wide enough to hold a scan limit up to the bitmap width.
	localparam int SCAN_W = 7;

	localparam int NUM_PROCESSES_DEF = 16;
	localparam int PAGES_PER_PROCESS_DEF = 32;
	localparam int PAGE_BYTES_DEF = 128;

	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

endpackage

### rtl/lru_page_victim_select.sv
// LRU page victim selector, top level and only module.
// Depends on lpvs_pkg for field widths and parameter defaults.
`timescale 1ns / 1ps

// Takes one process entry per request and returns one result per request.
// After reset the block runs a clearing pass over the timestamp memory,
// one entry per cycle, over every one of its entries
// (512 with the defaults), and holds req_stall high until it is done.
// A request that needs no victim search passes from IDLE through DECODE and FIN
// back to IDLE. A request that needs a search (active entry in range, page not
// resident and memory full) also passes through SCAN, which reads L stored
// timestamps, where L is the smaller of page_count, PAGES_PER_PROCESS and 32: the
// search reads one stored timestamp per cycle through the single read port of the
// memory, and the last compare and the end check follow the last read.
// A finished result waits in the output register while the next request is
// already taken in.
module lru_page_victim_select
	import lpvs_pkg::*;
#(
	parameter int NUM_PROCESSES = NUM_PROCESSES_DEF,
	parameter int PAGES_PER_PROCESS = PAGES_PER_PROCESS_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [PROC_IDX_W-1:0] process_index,
	input  logic                  active,
	input  logic [PC_W-1:0]       program_counter,
	input  logic [BITMAP_W-1:0]   resident_pages,
	input  logic [COUNT_W-1:0]    page_count,
	input  logic                  memory_full,
	input  logic                  last_of_tick,

	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  want_pagein,
	output logic [PAGE_OUT_W-1:0] pagein_page,
	output logic                  want_pageout,
	output logic [PAGE_OUT_W-1:0] victim_page
);

	localparam int PROC_W = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
	localparam int PG_W = $clog2(PAGES_PER_PROCESS);
	localparam int ADDR_W = PROC_W + PG_W;
	localparam int DEPTH = 1 << ADDR_W;

	// Division of the program counter by the page size as a multiply by
	// a rounded-up reciprocal; exact for every 12-bit dividend.
	localparam int DIV_L = $clog2(PAGE_BYTES);
	localparam int DIV_SHIFT = PC_W + DIV_L;
	localparam longint RECIP = ((64'd1 << DIV_SHIFT) + PAGE_BYTES - 1) / PAGE_BYTES;
	localparam int RECIP_W = PC_W + 2;
	localparam int PROD_W = PC_W + RECIP_W;

	localparam int SCAN_MAX = (PAGES_PER_PROCESS < BITMAP_W) ? PAGES_PER_PROCESS : BITMAP_W;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DECODE = 3'd2;
	localparam logic [2:0] ST_SCAN   = 3'd3;
	localparam logic [2:0] ST_FIN    = 3'd4;

	logic [2:0]            state_q;
	logic [ADDR_W-1:0]     clr_addr_q;
	logic [TICK_W-1:0]     now_tick_q;

	logic [PROC_IDX_W-1:0] proc_s1;
	logic                  active_s1;
	logic [PAGE_NUM_W-1:0] page_s1;
	logic [BITMAP_W-1:0]   resident_s1;
	logic [COUNT_W-1:0]    count_s1;
	logic                  full_s1;
	logic                  last_s1;

	logic [SCAN_W-1:0]     scan_p_q;
	logic [SCAN_W-1:0]     limit_q;
	logic                  rd_vld_s1;
	logic                  consider_s1;
	logic [PG_W-1:0]       rd_page_s1;
	logic [TICK_W-1:0]     rd_data_s1;

	logic                  found_q;
	logic [TICK_W-1:0]     best_time_q;
	logic [PG_W-1:0]       best_page_q;
	logic                  want_in_q;
	logic [PAGE_OUT_W-1:0] in_page_q;

	logic                  res_valid_q;
	logic                  want_pagein_q;
	logic [PAGE_OUT_W-1:0] pagein_page_q;
	logic                  want_pageout_q;
	logic [PAGE_OUT_W-1:0] victim_page_q;

	logic [TICK_W-1:0]     mem [DEPTH];
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_wa;
	logic [TICK_W-1:0]     mem_wd;
	logic                  mem_re;
	logic [ADDR_W-1:0]     mem_ra;

	logic [PROD_W-1:0]     div_prod;
	logic [PAGE_NUM_W-1:0] page_calc;
	logic [5:0]            proc_ext;
	logic [PROC_W-1:0]     proc_addr;
	logic                  entry_ok;
	logic                  page_resident;
	logic [SCAN_W-1:0]     limit_calc;
	logic                  accept;
	logic                  out_free;
	logic                  scan_issue;

	assign div_prod = PROD_W'(program_counter) * PROD_W'(RECIP);
	assign page_calc = PAGE_NUM_W'(div_prod >> DIV_SHIFT);

	assign proc_ext = 6'(proc_s1);
	assign proc_addr = proc_ext[PROC_W-1:0];

	assign entry_ok = active_s1 && (32'(proc_s1) < 32'(NUM_PROCESSES))
		&& (32'(page_s1) < 32'(PAGES_PER_PROCESS));
	assign page_resident = (32'(page_s1) < 32'(BITMAP_W)) && resident_s1[page_s1[4:0]];

	always_comb begin
		limit_calc = SCAN_W'(count_s1);
		if (32'(count_s1) > 32'(SCAN_MAX)) begin
			limit_calc = SCAN_W'(SCAN_MAX);
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign accept = req_valid && !req_stall;
	assign out_free = !res_valid_q || !res_stall;
	assign scan_issue = (state_q == ST_SCAN) && (scan_p_q < limit_q);

	// One write port shared by the clearing pass and the timestamp update.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_addr_q;
		mem_wd = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == ST_DECODE && entry_ok) begin
			mem_we = 1'b1;
			mem_wa = {proc_addr, page_s1[PG_W-1:0]};
			mem_wd = now_tick_q;
		end
	end

	assign mem_re = scan_issue;
	assign mem_ra = {proc_addr, scan_p_q[PG_W-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			proc_s1 <= process_index;
			active_s1 <= active;
			page_s1 <= page_calc;
			resident_s1 <= resident_pages;
			count_s1 <= page_count;
			full_s1 <= memory_full;
			last_s1 <= last_of_tick;
		end
		if (scan_issue) begin
			rd_page_s1 <= scan_p_q[PG_W-1:0];
			consider_s1 <= resident_s1[scan_p_q[4:0]] && (PAGE_NUM_W'(scan_p_q) != page_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			now_tick_q <= TICK_W'(1);
			scan_p_q <= '0;
			limit_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			best_time_q <= '0;
			best_page_q <= '0;
			want_in_q <= 1'b0;
			in_page_q <= '0;
			res_valid_q <= 1'b0;
			want_pagein_q <= 1'b0;
			pagein_page_q <= '0;
			want_pageout_q <= 1'b0;
			victim_page_q <= '0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			rd_vld_s1 <= scan_issue;

			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					want_in_q <= entry_ok && !page_resident;
					in_page_q <= entry_ok ? page_s1[PAGE_OUT_W-1:0] : '0;
					found_q <= 1'b0;
					best_time_q <= '0;
					best_page_q <= '0;
					scan_p_q <= '0;
					limit_q <= limit_calc;
					if (last_s1 && now_tick_q != TICK_MAX) begin
						now_tick_q <= now_tick_q + 1'b1;
					end
					if (entry_ok && !page_resident && full_s1) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						scan_p_q <= scan_p_q + 1'b1;
					end
					// Strict less-than keeps the lowest page on equal timestamps.
					if (rd_vld_s1 && consider_s1 && (!found_q || rd_data_s1 < best_time_q)) begin
						found_q <= 1'b1;
						best_time_q <= rd_data_s1;
						best_page_q <= rd_page_s1;
					end
					if (!scan_issue && !rd_vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						want_pagein_q <= want_in_q;
						pagein_page_q <= in_page_q;
						want_pageout_q <= found_q;
						victim_page_q <= found_q ? PAGE_OUT_W'(best_page_q) : '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign want_pagein = want_pagein_q;
	assign pagein_page = pagein_page_q;
	assign want_pageout = want_pageout_q;
	assign victim_page = victim_page_q;

`ifndef NO_ASSERTIONS
	// No result may appear before the timestamp memory has been cleared.
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !res_valid_q)
		else $error("result produced during clearing pass");

	// A page-out is only ever named together with a page-in.
	a_pageout_needs_pagein: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && want_pageout_q) |-> want_pagein_q)
		else $error("page-out without page-in");

	// The wanted page is never chosen as its own victim.
	a_victim_not_wanted: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && want_pageout_q) |-> (victim_page_q != pagein_page_q))
		else $error("victim equals the wanted page");

	// The search pointer never runs past its limit.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_p_q <= limit_q))
		else $error("scan pointer beyond limit");

	// The tick starts at one and only counts up, so it is never zero.
	a_tick_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		now_tick_q != '0)
		else $error("tick counter reached zero");
`endif

endmodule

### tb/sv/lpvs_checker.sv
// Scoreboard for the LRU page victim selector: watches both channels,
// predicts each result from its own timestamp store and compares in order.
// Depends on lpvs_pkg for field widths and default parameter values.
`timescale 1ns / 1ps

module lpvs_checker
	import lpvs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_stall,
	input  logic [PROC_IDX_W-1:0] process_index,
	input  logic                  active,
	input  logic [PC_W-1:0]       program_counter,
	input  logic [BITMAP_W-1:0]   resident_pages,
	input  logic [COUNT_W-1:0]    page_count,
	input  logic                  memory_full,
	input  logic                  last_of_tick,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  logic                  want_pagein,
	input  logic [PAGE_OUT_W-1:0] pagein_page,
	input  logic                  want_pageout,
	input  logic [PAGE_OUT_W-1:0] victim_page,
	output int                    fail_count,
	output int                    outstanding,
	output int                    checked,
	output int                    evictions
);

	typedef struct packed {
		logic                  want_in;
		logic [PAGE_OUT_W-1:0] in_page;
		logic                  want_out;
		logic [PAGE_OUT_W-1:0] victim;
	} page_result_t;

	logic [TICK_W-1:0] stamp_mem [NUM_PROCESSES_DEF][PAGES_PER_PROCESS_DEF];
	logic [TICK_W-1:0] tick_now;
	page_result_t      pending_q [$];
	int                errs = 0;
	int                n_checked = 0;
	int                n_evict = 0;

	function automatic logic is_resident(input logic [BITMAP_W-1:0] bitmap, input int p);
		return (p < BITMAP_W) && bitmap[p];
	endfunction

	// Predicts the result of one request and updates the timestamp store and the tick exactly as the block does.
	function automatic page_result_t lru_predict(
		input logic [PROC_IDX_W-1:0] proc,
		input logic                  act,
		input logic [PC_W-1:0]       pc,
		input logic [BITMAP_W-1:0]   bitmap,
		input logic [COUNT_W-1:0]    cnt,
		input logic                  full,
		input logic                  last
	);
		page_result_t      r;
		int                page;
		int                limit;
		int                p;
		logic              found;
		logic [TICK_W-1:0] oldest;
		r = '0;
		found = 1'b0;
		oldest = '0;
		page = int'(pc) / PAGE_BYTES_DEF;
		if (act && int'(proc) < NUM_PROCESSES_DEF && page < PAGES_PER_PROCESS_DEF) begin
			stamp_mem[proc][page] = tick_now;
			r.in_page = page[PAGE_OUT_W-1:0];
			if (!is_resident(bitmap, page)) begin
				r.want_in = 1'b1;
				if (full) begin
					limit = (int'(cnt) > PAGES_PER_PROCESS_DEF) ? PAGES_PER_PROCESS_DEF
						: int'(cnt);
					for (p = 0; p < limit; p++) begin
						// Strict compare keeps the lowest index on equal timestamps.
						if (p != page && is_resident(bitmap, p) &&
								(!found || stamp_mem[proc][p] < oldest)) begin
							found = 1'b1;
							oldest = stamp_mem[proc][p];
							r.victim = p[PAGE_OUT_W-1:0];
						end
					end
					r.want_out = found;
				end
			end
		end
		if (last && tick_now != TICK_MAX)
			tick_now++;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		page_result_t want;
		int i;
		int j;
		if (!arst_n) begin
			for (i = 0; i < NUM_PROCESSES_DEF; i++)
				for (j = 0; j < PAGES_PER_PROCESS_DEF; j++)
					stamp_mem[i][j] = '0;
			tick_now = 1;
			pending_q.delete();
		end else begin
			if (res_valid && !res_stall) begin
				if (pending_q.size() == 0) begin
					$display("%0t: result with no request waiting: pagein %0b/%0d pageout %0b/%0d",
						$time, want_pagein, pagein_page, want_pageout, victim_page);
					errs++;
				end else begin
					want = pending_q.pop_front();
					check_field("want_pagein", int'(want.want_in), int'(want_pagein));
					check_field("pagein_page", int'(want.in_page), int'(pagein_page));
					check_field("want_pageout", int'(want.want_out), int'(want_pageout));
					check_field("victim_page", int'(want.victim), int'(victim_page));
					n_checked++;
					if (want.want_out)
						n_evict++;
				end
			end
			if (req_valid && !req_stall)
				pending_q.push_back(lru_predict(process_index, active, program_counter,
					resident_pages, page_count, memory_full, last_of_tick));
		end
		fail_count <= errs;
		outstanding <= pending_q.size();
		checked <= n_checked;
		evictions <= n_evict;
	end

endmodule

### tb/sv/lru_page_victim_select_tb.sv
// Top of the LRU page victim selector testbench: clock, reset, request stimulus,
// result-side stalls, watchdog and verdict. Depends on lpvs_pkg, the block and lpvs_checker.
`timescale 1ns / 1ps

module lru_page_victim_select_tb
	import lpvs_pkg::*;
();

	localparam int IDLE_LIMIT = 4000;
	localparam int ACTIVE_TARGET = 800;

	typedef struct packed {
		logic [PROC_IDX_W-1:0] proc;
		logic                  act;
		logic [PC_W-1:0]       pc;
		logic [BITMAP_W-1:0]   res;
		logic [COUNT_W-1:0]    cnt;
		logic                  full;
		logic                  last;
	} page_req_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	logic [PROC_IDX_W-1:0] process_index = '0;
	logic                  active = 1'b0;
	logic [PC_W-1:0]       program_counter = '0;
	logic [BITMAP_W-1:0]   resident_pages = '0;
	logic [COUNT_W-1:0]    page_count = '0;
	logic                  memory_full = 1'b0;
	logic                  last_of_tick = 1'b0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic                  want_pagein;
	logic [PAGE_OUT_W-1:0] pagein_page;
	logic                  want_pageout;
	logic [PAGE_OUT_W-1:0] victim_page;

	logic park_req = 1'b0;
	logic park_done = 1'b0;
	int   fail_count;
	int   outstanding;
	int   checked;
	int   evictions;
	int   n_sent = 0;
	int   n_active = 0;

	lru_page_victim_select u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.process_index(process_index), .active(active), .program_counter(program_counter),
		.resident_pages(resident_pages), .page_count(page_count),
		.memory_full(memory_full), .last_of_tick(last_of_tick),
		.res_valid(res_valid), .res_stall(res_stall),
		.want_pagein(want_pagein), .pagein_page(pagein_page),
		.want_pageout(want_pageout), .victim_page(victim_page)
	);

	lpvs_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.process_index(process_index), .active(active), .program_counter(program_counter),
		.resident_pages(resident_pages), .page_count(page_count),
		.memory_full(memory_full), .last_of_tick(last_of_tick),
		.res_valid(res_valid), .res_stall(res_stall),
		.want_pagein(want_pagein), .pagein_page(pagein_page),
		.want_pageout(want_pageout), .victim_page(victim_page),
		.fail_count(fail_count), .outstanding(outstanding),
		.checked(checked), .evictions(evictions)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic page_req_t mk(input int proc, input int act, input int pc,
			input logic [BITMAP_W-1:0] res, input int cnt, input int full, input int last);
		page_req_t q;
		q.proc = PROC_IDX_W'(proc);
		q.act = 1'(act);
		q.pc = PC_W'(pc);
		q.res = res;
		q.cnt = COUNT_W'(cnt);
		q.full = 1'(full);
		q.last = 1'(last);
		return q;
	endfunction

	// Mostly page faults with memory full on a few busy processes, so that the
	// victim search runs against timestamps from many different ticks.
	function automatic page_req_t random_req();
		page_req_t q;
		int r;
		int page;
		r = $urandom_range(0, 99);
		q.proc = ($urandom_range(0, 9) < 7) ? PROC_IDX_W'($urandom_range(0, 3))
			: PROC_IDX_W'($urandom_range(0, 15));
		q.act = ($urandom_range(0, 9) != 0);
		q.pc = PC_W'($urandom());
		q.res = $urandom();
		if ($urandom_range(0, 3) == 0)
			q.res = q.res & $urandom() & $urandom();
		q.cnt = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(33, 63))
			: COUNT_W'($urandom_range(0, 32));
		q.full = 1'($urandom_range(0, 1));
		q.last = ($urandom_range(0, 3) == 0);
		page = int'(q.pc) / PAGE_BYTES_DEF;
		if (r < 65) begin
			q.act = 1'b1;
			q.full = 1'b1;
			q.res[page] = 1'b0;
		end else if (r < 85) begin
			q.act = 1'b1;
			q.res[page] = 1'($urandom_range(0, 1));
		end
		return q;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	task automatic send_item(input page_req_t q, input int gap);
		req_valid <= 1'b1;
		process_index <= q.proc;
		active <= q.act;
		program_counter <= q.pc;
		resident_pages <= q.res;
		page_count <= q.cnt;
		memory_full <= q.full;
		last_of_tick <= q.last;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		n_sent++;
		if (q.act)
			n_active++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// The extra edge lets the count of the request taken last become visible.
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off when the stimulus asks for it.
	initial begin
		int r;
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (park_req && !park_done) begin
				res_stall <= 1'b1;
				repeat (300) @(posedge clk);
				park_done <= 1'b1;
			end else if (r < 50) begin
				res_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else if (r < 90) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				res_stall <= 1'b1;
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				idle = 0;
			else
				idle++;
		end
		$display("Timed out after %0d cycles with no request or result moving.", IDLE_LIMIT);
		$display("lru_page_victim_select_tb: FAIL");
		$finish;
	end

	initial begin
		int k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes, hits, ties, empty and truncated scans, stale versus fresh pages.
		send_item(mk(15, 0, 12'hFFF, 32'hFFFF_FFFF, 63, 1, 0), pick_gap());
		send_item(mk(0, 1, 12'h000, 32'h0000_0000, 0, 0, 0), pick_gap());
		send_item(mk(0, 1, 12'h0FF, 32'h0000_0001, 32, 1, 0), pick_gap());
		send_item(mk(0, 1, 12'h07F, 32'h0000_0001, 32, 1, 1), pick_gap());
		send_item(mk(1, 1, 12'h2A5, 32'h0000_0000, 32, 1, 0), pick_gap());
		send_item(mk(1, 1, 12'h1C0, 32'hFFFF_FFF7, 0, 1, 0), pick_gap());
		send_item(mk(15, 1, 12'hFFF, 32'h7FFF_FFFF, 63, 1, 1), pick_gap());
		send_item(mk(2, 1, 12'h200, 32'hF0F0_0F00, 32, 1, 0), pick_gap());
		send_item(mk(2, 1, 12'h400, 32'hF0F0_0F00, 32, 1, 1), pick_gap());
		send_item(mk(2, 1, 12'h200, 32'hF0F0_0F00, 32, 1, 0), pick_gap());
		send_item(mk(3, 1, 12'h500, 32'hFFFF_FBFF, 1, 1, 0), pick_gap());
		send_item(mk(3, 1, 12'h500, 32'hFFFF_FBFE, 2, 1, 1), pick_gap());
		send_item(mk(4, 1, 12'h000, 32'h0000_000F, 4, 0, 1), pick_gap());
		send_item(mk(4, 1, 12'h080, 32'h0000_000F, 4, 0, 1), pick_gap());
		send_item(mk(4, 1, 12'h100, 32'h0000_000F, 4, 0, 1), pick_gap());
		send_item(mk(4, 1, 12'h180, 32'h0000_0007, 4, 1, 0), pick_gap());
		send_item(mk(4, 1, 12'h000, 32'h0000_0007, 4, 1, 1), pick_gap());
		send_item(mk(4, 1, 12'h180, 32'h0000_0007, 4, 1, 0), pick_gap());
		send_item(mk(7, 0, 12'h123, 32'h0000_0000, 5, 0, 1), pick_gap());
		send_item(mk(9, 1, 12'hF80, 32'h8000_0000, 32, 1, 0), pick_gap());
		send_item(mk(9, 1, 12'hF00, 32'h8000_0000, 32, 1, 0), pick_gap());
		send_item(mk(9, 1, 12'hF00, 32'h8000_0000, 31, 1, 0), pick_gap());

		// Sender pause until every outstanding result has been returned.
		wait_drained();

		while (n_active < 300)
			send_item(random_req(), pick_gap());

		// Result side holds off for a long stretch while requests keep coming.
		park_req <= 1'b1;
		@(posedge clk);
		while (!park_done)
			send_item(random_req(), 0);

		for (k = 0; k < 100; k++)
			send_item(random_req(), 0);
		while (n_active < ACTIVE_TARGET)
			send_item(random_req(), pick_gap());

		wait_drained();
		repeat (40) @(posedge clk);

		$display("Sent %0d requests (%0d for active processes); %0d results checked.",
			n_sent, n_active, checked);
		$display("Results naming a page-out victim: %0d; mismatches: %0d.",
			evictions, fail_count);
		if (fail_count == 0 && outstanding == 0)
			$display("lru_page_victim_select_tb: PASS");
		else
			$display("lru_page_victim_select_tb: FAIL");
		$finish;
	end

endmodule

### files.f
rtl/lpvs_pkg.sv
rtl/lru_page_victim_select.sv
tb/sv/lpvs_checker.sv
tb/sv/lru_page_victim_select_tb.sv
